// File: rtl/core/wav_pkg.sv
package wav_pkg;

    typedef enum logic [3:0] {
        PH_RIFF = 4'd0,
        PH_LEN  = 4'd1,
        PH_WAVE = 4'd2,
        PH_HDR  = 4'd3,
        PH_FMT  = 4'd4,
        PH_DATA = 4'd5,
        PH_SKIP = 4'd6,
        PH_PAD  = 4'd7,
        PH_DONE = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_NOT_RIFF    = 4'd2,
        ST_SIZE        = 4'd3,
        ST_NOT_WAVE    = 4'd4,
        ST_CHUNK_CUT   = 4'd5,
        ST_FMT_SHORT   = 4'd6,
        ST_BAD_FORMAT  = 4'd7,
        ST_NO_CHANNELS = 4'd8,
        ST_NO_RATE     = 4'd9,
        ST_BAD_DEPTH   = 4'd10,
        ST_NO_FMT      = 4'd11,
        ST_NO_DATA     = 4'd12
    } t_status;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // 2^31 = 255 * K8 + 128 and 2^31 = 32767 * K16 + 2.
    localparam logic [23:0] K8  = 24'd8421504;
    localparam logic [16:0] K16 = 17'd65538;

    // Rounded, saturated Q1.31 from a sign and an unsigned quotient.
    function automatic logic [31:0] q31_sat(input logic neg, input logic [32:0] q);
        logic [31:0] r;
        if (neg) begin
            r = (q > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end else begin
            r = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    // 8-bit unsigned: (2u-255)/255 scaled by 2^31.
    function automatic logic [31:0] conv_u8(input logic [7:0] u);
        logic        neg;
        logic [7:0]  mag;
        logic [15:0] x;
        logic [7:0]  d;
        logic [32:0] q;
        neg = (u < 8'd128);
        mag = neg ? (8'd255 - {u[6:0], 1'b0}) : ({u[6:0], 1'b0} + 8'd1);
        x   = {1'b0, mag, 7'd0} + 16'd127;
        // floor(x / 255) for x below 65535.
        d   = 8'((x + 16'(x[15:8]) + 16'd1) >> 8);
        q   = 33'(mag) * 33'(K8) + 33'(d);
        return q31_sat(neg, q);
    endfunction

    // 16-bit signed: s/32767 scaled by 2^31.
    function automatic logic [31:0] conv_s16(input logic [15:0] s);
        logic        neg;
        logic [16:0] mag;
        logic [17:0] x;
        logic [1:0]  d;
        logic [32:0] q;
        neg = s[15];
        mag = neg ? (17'h1_0000 - {1'b0, s}) : {1'b0, s};
        x   = {mag, 1'b0} + 18'd16383;
        d   = (x >= 18'd65534) ? 2'd2 : ((x >= 18'd32767) ? 2'd1 : 2'd0);
        q   = 33'(mag) * 33'(K16) + 33'(d);
        return q31_sat(neg, q);
    endfunction

endpackage

// File: rtl/core/wav_stream_parser_sample_converter.sv
// Channel | Direction | Beat                      | Handshake
// in      | input     | byte_in, end_of_file      | i_in_valid / o_in_ready
// out     | output    | sample and status result  | o_out_valid / i_out_ready
//
// Each byte is captured in an input register and parsed from that register,
// one byte per cycle while the output is taken, with the result landing in the output register.
// A result passes the input register and then the output register; throughput is
// one byte per cycle while the output is taken. Reset is synchronous and clears
// the parser state and both registers' valid flags. A stalled output holds
// the parse stage, which in turn holds the input register.
module wav_stream_parser_sample_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_sample_valid,
    output logic signed [31:0] o_sample_value,
    output logic        o_sample_is_float,
    output logic [15:0] o_channel_index,
    output logic        o_finished,
    output logic [3:0]  o_status_code,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [5:0]  o_sample_bits
);
    import wav_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_eof;

    t_phase      r_phase, n_phase;
    logic [31:0] r_total, n_total;
    logic [31:0] r_riff_len, n_riff_len;
    logic [31:0] r_fcnt, n_fcnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_fmt_tag, n_fmt_tag;
    logic [15:0] r_chans, n_chans;
    logic [31:0] r_rate, n_rate;
    logic [7:0]  r_bits, n_bits;
    logic [31:0] r_asm, n_asm;
    logic [1:0]  r_sidx, n_sidx;
    logic [15:0] r_chcnt, n_chcnt;
    logic        r_seen_fmt, n_seen_fmt;
    logic        r_seen_data, n_seen_data;
    logic        r_err_lat, n_err_lat;

    logic        r_out_vld;
    logic        r_o_sv;
    logic [31:0] r_o_val;
    logic        r_o_isf;
    logic [15:0] r_o_ch;
    logic        r_o_fin;
    logic [3:0]  r_o_st;
    logic [15:0] r_o_cc;
    logic [31:0] r_o_rate;
    logic [5:0]  r_o_bits;

    logic        proc;
    logic        res_vld;
    logic        sv;
    logic [31:0] sval;
    logic        isf;
    logic [15:0] ch;
    logic        fin;
    t_status     err;
    t_status     status;
    logic        cut;
    logic [2:0]  per;
    logic [31:0] word;

    assign proc       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || proc;

    always_comb begin
        n_phase     = r_phase;
        n_total     = r_total;
        n_riff_len  = r_riff_len;
        n_fcnt      = r_fcnt;
        n_tag       = r_tag;
        n_rem       = r_rem;
        n_fmt_tag   = r_fmt_tag;
        n_chans     = r_chans;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_asm       = r_asm;
        n_sidx      = r_sidx;
        n_chcnt     = r_chcnt;
        n_seen_fmt  = r_seen_fmt;
        n_seen_data = r_seen_data;
        n_err_lat   = r_err_lat;
        err    = ST_OK;
        status = ST_OK;
        sv     = 1'b0;
        sval   = 32'd0;
        isf    = 1'b0;
        ch     = 16'd0;
        fin    = 1'b0;
        cut    = 1'b0;
        per    = 3'd1;
        word   = 32'd0;

        if (r_phase != PH_DONE) begin
            if (r_total != 32'hFFFF_FFFF) begin
                n_total = r_total + 32'd1;
            end
            case (r_phase)
                PH_RIFF: begin
                    n_tag  = {r_in_byte, r_tag[31:8]};
                    n_fcnt = r_fcnt + 32'd1;
                    if (n_fcnt == 32'd4) begin
                        n_fcnt = 32'd0;
                        if (n_tag != TAG_RIFF) err = ST_NOT_RIFF;
                        else n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_riff_len = {r_in_byte, r_riff_len[31:8]};
                    n_fcnt     = r_fcnt + 32'd1;
                    if (n_fcnt == 32'd4) begin
                        n_fcnt  = 32'd0;
                        n_phase = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    n_tag  = {r_in_byte, r_tag[31:8]};
                    n_fcnt = r_fcnt + 32'd1;
                    if (n_fcnt == 32'd4) begin
                        n_fcnt = 32'd0;
                        if (r_riff_len < 32'd4 || n_tag != TAG_WAVE) err = ST_NOT_WAVE;
                        else n_phase = PH_HDR;
                    end
                end
                PH_HDR: begin
                    if (r_fcnt < 32'd4) n_tag = {r_in_byte, r_tag[31:8]};
                    else n_rem = {r_in_byte, r_rem[31:8]};
                    n_fcnt = r_fcnt + 32'd1;
                    if (n_fcnt == 32'd8) begin
                        n_fcnt = 32'd0;
                        if (r_in_eof && n_rem != 32'd0) begin
                            n_phase = PH_SKIP;
                        end else if (n_tag == TAG_FMT) begin
                            if (n_rem < 32'd16) err = ST_FMT_SHORT;
                            else n_phase = PH_FMT;
                        end else if (n_tag == TAG_DATA) begin
                            if (!r_seen_fmt) begin
                                err = ST_NO_FMT;
                            end else begin
                                n_seen_data = 1'b1;
                                n_chcnt = 16'd0;
                                n_sidx  = 2'd0;
                                n_asm   = 32'd0;
                                n_phase = (n_rem != 32'd0) ? PH_DATA : PH_HDR;
                            end
                        end else begin
                            n_phase = (n_rem != 32'd0) ? PH_SKIP : PH_HDR;
                        end
                    end
                end
                PH_FMT: begin
                    case (r_fcnt)
                        32'd0: n_fmt_tag = {8'd0, r_in_byte};
                        32'd1: begin
                            n_fmt_tag = {r_in_byte, r_fmt_tag[7:0]};
                            if (n_fmt_tag != FMT_PCM && n_fmt_tag != FMT_FLOAT)
                                err = ST_BAD_FORMAT;
                        end
                        32'd2: n_chans = {8'd0, r_in_byte};
                        32'd3: begin
                            n_chans = {r_in_byte, r_chans[7:0]};
                            if (n_chans == 16'd0) err = ST_NO_CHANNELS;
                        end
                        32'd4, 32'd5, 32'd6: n_rate = {r_in_byte, r_rate[31:8]};
                        32'd7: begin
                            n_rate = {r_in_byte, r_rate[31:8]};
                            if (n_rate == 32'd0) err = ST_NO_RATE;
                        end
                        32'd14: n_bits = r_in_byte;
                        32'd15: begin
                            if (r_in_byte != 8'd0 ||
                                (r_bits != 8'd8 && r_bits != 8'd16 &&
                                 r_bits != 8'd24 && r_bits != 8'd32) ||
                                (r_fmt_tag == FMT_FLOAT && r_bits != 8'd32))
                                err = ST_BAD_DEPTH;
                            else
                                n_seen_fmt = 1'b1;
                        end
                        default: ;
                    endcase
                    if (err == ST_OK) begin
                        n_fcnt = r_fcnt + 32'd1;
                        n_rem  = r_rem - 32'd1;
                        if (n_rem == 32'd0) begin
                            n_phase = n_fcnt[0] ? PH_PAD : PH_HDR;
                            n_fcnt  = 32'd0;
                        end
                    end
                end
                PH_DATA: begin
                    if (r_bits[7:5] != 3'd0) per = 3'd4;
                    else if (r_bits[4:3] == 2'd0) per = 3'd1;
                    else per = {1'b0, r_bits[4:3]};
                    word = r_asm | ({24'd0, r_in_byte} << {r_sidx, 3'd0});
                    if ({1'b0, r_sidx} + 3'd1 >= per) begin
                        sv  = 1'b1;
                        isf = (r_fmt_tag == FMT_FLOAT);
                        if (isf) sval = word;
                        else if (r_bits == 8'd8) sval = conv_u8(word[7:0]);
                        else if (r_bits == 8'd16) sval = conv_s16(word[15:0]);
                        else if (r_bits == 8'd24) sval = {word[23:0], 8'd0};
                        else sval = word;
                        ch = r_chcnt;
                        n_chcnt = ({1'b0, r_chcnt} + 17'd1 >= {1'b0, r_chans}) ?
                                  16'd0 : r_chcnt + 16'd1;
                        n_asm  = 32'd0;
                        n_sidx = 2'd0;
                    end else begin
                        n_asm  = word;
                        n_sidx = r_sidx + 2'd1;
                    end
                    n_fcnt = r_fcnt + 32'd1;
                    n_rem  = r_rem - 32'd1;
                    if (n_rem == 32'd0) begin
                        n_phase = n_fcnt[0] ? PH_PAD : PH_HDR;
                        n_fcnt  = 32'd0;
                    end
                end
                PH_SKIP: begin
                    n_fcnt = r_fcnt + 32'd1;
                    n_rem  = (r_rem == 32'd0) ? 32'd0 : r_rem - 32'd1;
                    if (r_rem <= 32'd1) begin
                        n_phase = n_fcnt[0] ? PH_PAD : PH_HDR;
                        n_fcnt  = 32'd0;
                    end
                end
                default: begin
                    n_phase = PH_HDR;
                    n_fcnt  = 32'd0;
                end
            endcase

            if (r_in_eof) begin
                cut = (n_phase == PH_HDR && n_fcnt != 32'd0) || n_phase == PH_FMT ||
                      n_phase == PH_DATA || n_phase == PH_SKIP;
                fin = 1'b1;
                if (n_total < 32'd12) status = ST_SHORT;
                else if ({1'b0, n_total} < {1'b0, n_riff_len} + 33'd8) status = ST_SIZE;
                else if (cut) status = ST_CHUNK_CUT;
                else if (err != ST_OK) status = err;
                else if (!n_seen_fmt) status = ST_NO_FMT;
                else if (!n_seen_data) status = ST_NO_DATA;
                else status = ST_OK;
            end else if (err != ST_OK) begin
                fin    = 1'b1;
                status = err;
            end
            if (fin) begin
                n_phase   = PH_DONE;
                n_err_lat = (status != ST_OK);
            end
        end
        res_vld = sv || fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_phase     <= PH_RIFF;
            r_total     <= 32'd0;
            r_riff_len  <= 32'd0;
            r_fcnt      <= 32'd0;
            r_tag       <= 32'd0;
            r_rem       <= 32'd0;
            r_fmt_tag   <= 16'd0;
            r_chans     <= 16'd0;
            r_rate      <= 32'd0;
            r_bits      <= 8'd0;
            r_asm       <= 32'd0;
            r_sidx      <= 2'd0;
            r_chcnt     <= 16'd0;
            r_seen_fmt  <= 1'b0;
            r_seen_data <= 1'b0;
            r_err_lat   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (proc) begin
                r_phase     <= n_phase;
                r_total     <= n_total;
                r_riff_len  <= n_riff_len;
                r_fcnt      <= n_fcnt;
                r_tag       <= n_tag;
                r_rem       <= n_rem;
                r_fmt_tag   <= n_fmt_tag;
                r_chans     <= n_chans;
                r_rate      <= n_rate;
                r_bits      <= n_bits;
                r_asm       <= n_asm;
                r_sidx      <= n_sidx;
                r_chcnt     <= n_chcnt;
                r_seen_fmt  <= n_seen_fmt;
                r_seen_data <= n_seen_data;
                r_err_lat   <= n_err_lat;
                r_out_vld   <= res_vld;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
            r_in_eof  <= i_end_of_file;
        end
        if (proc && res_vld) begin
            r_o_sv   <= sv;
            r_o_val  <= sval;
            r_o_isf  <= isf;
            r_o_ch   <= ch;
            r_o_fin  <= fin;
            r_o_st   <= status;
            r_o_cc   <= n_chans;
            r_o_rate <= n_rate;
            r_o_bits <= n_bits[5:0];
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_sample_valid    = r_o_sv;
    assign o_sample_value    = r_o_val;
    assign o_sample_is_float = r_o_isf;
    assign o_channel_index   = r_o_ch;
    assign o_finished        = r_o_fin;
    assign o_status_code     = r_o_st;
    assign o_channel_count   = r_o_cc;
    assign o_sample_rate     = r_o_rate;
    assign o_sample_bits     = r_o_bits;

    // A result always carries a sample or a final status.
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_valid || o_finished))
        else $error("result with neither sample nor status");

    a_status_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_finished) |-> (o_status_code == ST_OK))
        else $error("nonzero status without finish");

    a_empty_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_sample_valid) |-> (o_sample_value == 32'd0 && !o_sample_is_float))
        else $error("sample fields set without a sample");

    // Once the final status has been produced the parser produces no further results.
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !r_out_vld) |=> !r_out_vld)
        else $error("result after finish");

endmodule

// File: test/tb_top.sv
module tb_top;
    import wav_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    typedef struct {
        logic        valid;
        logic [31:0] value;
        logic        is_float;
        logic [15:0] chan;
        logic        fin;
        logic [3:0]  status;
        logic [15:0] nchan;
        logic [31:0] rate;
        logic [5:0]  bits;
    } wav_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_in = 8'd0;
    logic        i_end_of_file = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_sample_valid;
    logic signed [31:0] o_sample_value;
    logic        o_sample_is_float;
    logic [15:0] o_channel_index;
    logic        o_finished;
    logic [3:0]  o_status_code;
    logic [15:0] o_channel_count;
    logic [31:0] o_sample_rate;
    logic [5:0]  o_sample_bits;

    wav_stream_parser_sample_converter dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    byte_beat_t  file_bytes[$];
    wav_result_t pending_results[$];
    int          n_bytes_in = 0;
    int          n_results = 0;
    int          n_samples = 0;
    bit          failed = 1'b0;
    logic [3:0]  final_status = ST_OK;

    // Parser model state.
    t_phase      m_phase = PH_RIFF;
    logic [31:0] m_seen = 0;
    logic [31:0] m_riff_len = 0;
    logic [31:0] m_offset = 0;
    logic [31:0] m_tag = 0;
    logic [31:0] m_remaining = 0;
    logic [15:0] m_fmt_tag = 0;
    logic [15:0] m_nchan = 0;
    logic [31:0] m_rate = 0;
    logic [7:0]  m_depth = 0;
    logic [31:0] m_word = 0;
    logic [1:0]  m_word_idx = 0;
    logic [31:0] m_chan_ctr = 0;
    bit          m_have_fmt = 0;
    bit          m_have_data = 0;

    function automatic logic [31:0] round_q31(bit neg, longint unsigned num,
                                              longint unsigned den);
        longint unsigned q;
        q = (num + den / 2) / den;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic logic [31:0] to_q31(logic [31:0] w);
        longint unsigned mag;
        bit neg;
        if (m_fmt_tag == FMT_FLOAT) return w;
        if (m_depth == 8'd8) begin
            neg = w[7:0] < 8'd128;
            mag = neg ? (255 - 2 * w[7:0]) : (2 * w[7:0] - 255);
            return round_q31(neg, mag << 31, 255);
        end
        if (m_depth == 8'd16) begin
            neg = w[15];
            mag = neg ? (65536 - w[15:0]) : w[15:0];
            return round_q31(neg, mag << 31, 32767);
        end
        if (m_depth == 8'd24) return {w[23:0], 8'd0};
        return w;
    endfunction

    function automatic void close_chunk();
        m_phase  = m_offset[0] ? PH_PAD : PH_HDR;
        m_offset = 0;
    endfunction

    // Advances the parser model by one byte; returns 1 when a result is due.
    function automatic bit parse_byte(logic [7:0] b, logic eof, output wav_result_t r);
        logic [3:0]  err;
        logic [31:0] per;
        bit cut;
        r = '{default: '0};
        err = ST_OK;
        if (m_phase == PH_DONE) return 0;
        if (m_seen != 32'hFFFF_FFFF) m_seen++;
        case (m_phase)
            PH_RIFF, PH_WAVE: begin
                m_tag = {b, m_tag[31:8]};
                if (++m_offset == 4) begin
                    m_offset = 0;
                    if (m_phase == PH_RIFF) begin
                        if (m_tag != TAG_RIFF) err = ST_NOT_RIFF;
                        else m_phase = PH_LEN;
                    end else if (m_riff_len < 4 || m_tag != TAG_WAVE) begin
                        err = ST_NOT_WAVE;
                    end else begin
                        m_phase = PH_HDR;
                    end
                end
            end
            PH_LEN: begin
                m_riff_len = {b, m_riff_len[31:8]};
                if (++m_offset == 4) begin
                    m_offset = 0;
                    m_phase = PH_WAVE;
                end
            end
            PH_HDR: begin
                if (m_offset < 4) m_tag = {b, m_tag[31:8]};
                else m_remaining = {b, m_remaining[31:8]};
                if (++m_offset == 8) begin
                    m_offset = 0;
                    if (eof && m_remaining != 0) begin
                        m_phase = PH_SKIP;
                    end else if (m_tag == TAG_FMT) begin
                        if (m_remaining < 16) err = ST_FMT_SHORT;
                        else m_phase = PH_FMT;
                    end else if (m_tag == TAG_DATA) begin
                        if (!m_have_fmt) begin
                            err = ST_NO_FMT;
                        end else begin
                            m_have_data = 1;
                            m_chan_ctr = 0;
                            m_word_idx = 0;
                            m_word = 0;
                            m_phase = (m_remaining != 0) ? PH_DATA : PH_HDR;
                        end
                    end else begin
                        m_phase = (m_remaining != 0) ? PH_SKIP : PH_HDR;
                    end
                end
            end
            PH_FMT: begin
                case (m_offset)
                    0: m_fmt_tag = {8'd0, b};
                    1: begin
                        m_fmt_tag[15:8] = b;
                        if (m_fmt_tag != FMT_PCM && m_fmt_tag != FMT_FLOAT)
                            err = ST_BAD_FORMAT;
                    end
                    2: m_nchan = {8'd0, b};
                    3: begin
                        m_nchan[15:8] = b;
                        if (m_nchan == 0) err = ST_NO_CHANNELS;
                    end
                    4, 5, 6: m_rate = {b, m_rate[31:8]};
                    7: begin
                        m_rate = {b, m_rate[31:8]};
                        if (m_rate == 0) err = ST_NO_RATE;
                    end
                    14: m_depth = b;
                    15: begin
                        if (b != 0 || !(m_depth inside {8, 16, 24, 32}) ||
                            (m_fmt_tag == FMT_FLOAT && m_depth != 32))
                            err = ST_BAD_DEPTH;
                        else
                            m_have_fmt = 1;
                    end
                    default: ;
                endcase
                if (err == ST_OK) begin
                    m_offset++;
                    if (--m_remaining == 0) close_chunk();
                end
            end
            PH_DATA: begin
                per = m_depth >> 3;
                if (per == 0) per = 1;
                if (per > 4) per = 4;
                m_word |= 32'(b) << (8 * m_word_idx);
                if (m_word_idx + 1 >= per) begin
                    r.valid = 1;
                    r.value = to_q31(m_word);
                    r.is_float = (m_fmt_tag == FMT_FLOAT);
                    r.chan = m_chan_ctr[15:0];
                    m_chan_ctr = (m_chan_ctr + 1 >= m_nchan) ? 0 : m_chan_ctr + 1;
                    m_word = 0;
                    m_word_idx = 0;
                end else begin
                    m_word_idx++;
                end
                m_offset++;
                if (--m_remaining == 0) close_chunk();
            end
            PH_SKIP: begin
                m_offset++;
                if (m_remaining == 0 || --m_remaining == 0) close_chunk();
            end
            default: begin
                m_phase = PH_HDR;
                m_offset = 0;
            end
        endcase

        if (eof) begin
            cut = (m_phase == PH_HDR && m_offset != 0) || m_phase == PH_FMT ||
                  m_phase == PH_DATA || m_phase == PH_SKIP;
            r.fin = 1;
            if (m_seen < 12) r.status = ST_SHORT;
            else if (33'(m_seen) < 33'(m_riff_len) + 33'd8) r.status = ST_SIZE;
            else if (cut) r.status = ST_CHUNK_CUT;
            else if (err != ST_OK) r.status = err;
            else if (!m_have_fmt) r.status = ST_NO_FMT;
            else if (!m_have_data) r.status = ST_NO_DATA;
            else r.status = ST_OK;
        end else if (err != ST_OK) begin
            r.fin = 1;
            r.status = err;
        end
        if (r.fin) m_phase = PH_DONE;
        r.nchan = m_nchan;
        r.rate = m_rate;
        r.bits = m_depth[5:0];
        return r.valid || r.fin;
    endfunction

    // File building.
    function automatic void put8(logic [7:0] b);
        file_bytes.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void put32(logic [31:0] w);
        for (int k = 0; k < 4; k++) put8(w[8*k +: 8]);
    endfunction

    function automatic void put_fmt(logic [15:0] tag, logic [15:0] nch, logic [31:0] rate,
                                    logic [15:0] depth, int extra);
        put32(TAG_FMT);
        put32(16 + extra);
        put8(tag[7:0]);
        put8(tag[15:8]);
        put8(nch[7:0]);
        put8(nch[15:8]);
        put32(rate);
        put32($urandom);
        put8(8'($urandom));
        put8(8'($urandom));
        put8(depth[7:0]);
        put8(depth[15:8]);
        for (int k = 0; k < extra; k++) put8(8'($urandom));
        if (extra % 2) put8(8'($urandom));
    endfunction

    function automatic void put_random_fmt();
        logic [15:0] nch;
        logic [15:0] depth;
        bit fl;
        fl = ($urandom_range(0, 4) == 0);
        depth = fl ? 16'd32 : 16'(8 * $urandom_range(1, 4));
        nch = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 3));
        put_fmt(fl ? FMT_FLOAT : FMT_PCM, nch, $urandom_range(1, 32'hFFFF_FFFF), depth,
                ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
    endfunction

    function automatic void put_data(int len);
        put32(TAG_DATA);
        put32(len);
        for (int k = 0; k < len; k++) put8(8'($urandom));
        if (len % 2) put8(8'($urandom));
    endfunction

    function automatic void build_file();
        int ending;
        int len;
        logic [31:0] tag;
        put32(TAG_RIFF);
        put32(0);
        put32(TAG_WAVE);
        // Sample extremes for 8-bit and 16-bit PCM first.
        put_fmt(FMT_PCM, 16'd2, 32'd44100, 16'd8, 0);
        put32(TAG_DATA);
        put32(5);
        put8(8'h00); put8(8'h7F); put8(8'h80); put8(8'hFF); put8(8'h01);
        put8(8'h00);
        put_fmt(FMT_PCM, 16'd1, 32'hFFFF_FFFF, 16'd16, 1);
        put32(TAG_DATA);
        put32(10);
        put8(8'h00); put8(8'h80); put8(8'hFF); put8(8'h7F);
        put8(8'h00); put8(8'h00); put8(8'hFF); put8(8'hFF);
        put8(8'h01); put8(8'h80);
        put_data(0);
        while (file_bytes.size() < 1300) begin
            case ($urandom_range(0, 5))
                0: put_random_fmt();
                1: begin
                    tag = $urandom;
                    if (tag == TAG_FMT || tag == TAG_DATA) tag = ~tag;
                    len = $urandom_range(0, 9);
                    put32(tag);
                    put32(len);
                    for (int k = 0; k < len + (len % 2); k++) put8(8'($urandom));
                end
                default: put_data(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48));
            endcase
        end
        ending = $urandom_range(0, 8);
        case (ending)
            1: begin
                put32(TAG_DATA);
                put32(40);
                for (int k = 0; k < 11; k++) put8(8'($urandom));
            end
            3: put_fmt(16'($urandom_range(4, 65535)), 16'd1, 32'd8000, 16'd8, 0);
            4: put_fmt(FMT_PCM, 16'd0, 32'd8000, 16'd8, 0);
            5: put_fmt(FMT_PCM, 16'd1, 32'd0, 16'd8, 0);
            6: put_fmt(FMT_FLOAT, 16'd1, 32'd8000, 16'd16, 0);
            7: put_fmt(FMT_PCM, 16'd1, 32'd8000, 16'h0110, 0);
            8: begin
                put32(TAG_FMT);
                put32($urandom_range(0, 15));
            end
            default: put_data($urandom_range(1, 20));
        endcase
        len = file_bytes.size() - 8 + ((ending == 2) ? $urandom_range(1, 64) : 0);
        for (int k = 0; k < 4; k++) file_bytes[4 + k].data = len[8*k +: 8];
        file_bytes[file_bytes.size() - 1].last = 1'b1;
        // Bytes after the end of the file must be ignored.
        for (int k = 0; k < 6; k++)
            file_bytes.push_back('{data: 8'($urandom), last: 1'($urandom)});
    endfunction

    // Sender: bursts with random gaps.
    int         burst_left = 0;
    int         gap_left = 0;
    byte_beat_t beat;
    wav_result_t predicted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                n_bytes_in++;
                if (parse_byte(i_byte_in, i_end_of_file, predicted))
                    pending_results.push_back(predicted);
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (file_bytes.size() != 0) begin
                    beat = file_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_byte_in <= beat.data;
                    i_end_of_file <= beat.last;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: randomly chosen stall modes.
    int          mode_left = 0;
    int          stall_mode = 0;
    wav_result_t want;

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat");
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (want.valid) n_samples++;
                if (want.fin) final_status = want.status;
                check_field("sample_valid", want.valid, o_sample_valid);
                check_field("sample_value", want.value, o_sample_value);
                check_field("sample_is_float", want.is_float, o_sample_is_float);
                check_field("channel_index", want.chan, o_channel_index);
                check_field("finished", want.fin, o_finished);
                check_field("status_code", want.status, o_status_code);
                check_field("channel_count", want.nchan, o_channel_count);
                check_field("sample_rate", want.rate, o_sample_rate);
                check_field("sample_bits", want.bits, o_sample_bits);
            end
        end
        if (mode_left == 0) begin
            mode_left = $urandom_range(1, 60);
            stall_mode = $urandom_range(0, 2);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        build_file();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (file_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Fed %0d bytes of one WAVE stream; checked %0d results, %0d of them samples.",
                 n_bytes_in, n_results, n_samples);
        $display("Stream closed with status %0d.", final_status);
        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timed out waiting for the stream to drain.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
